@@ hdl/lupp_pkg.sv @@
`timescale 1ns / 1ps

package lupp_pkg;

   localparam int ROW_W      = 4;
   localparam int COL_W      = 5;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int RESULT_CAP = 16;

   localparam logic [COL_W-1:0] BCOL = 5'd16;
   localparam logic [COL_W-1:0] XCOL = 5'd17;

   localparam logic STATUS_SOLVED = 1'b0;
   localparam logic STATUS_FAILED = 1'b1;

   localparam logic REG_ORDER     = 1'b0;
   localparam logic REG_TOLERANCE = 1'b1;

   typedef logic signed [31:0] q16_type;

   function automatic q16_type sat_mag(input logic neg, input logic [63:0] mag);
      q16_type res;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
         else res = q16_type'(mag[31:0]);
      end else begin
         if (mag > 64'h0000_0000_8000_0000) res = 32'sh8000_0000;
         else res = q16_type'(32'd0 - mag[31:0]);
      end
      return res;
   endfunction

endpackage

@@ hdl/lupp_qmul.sv @@
`timescale 1ns / 1ps

module lupp_qmul (
   input  logic               clock,
   input  logic               mul_en,
   input  lupp_pkg::q16_type  mul_a,
   input  lupp_pkg::q16_type  mul_b,
   output lupp_pkg::q16_type  mul_q
);

   logic signed [63:0] prod_ff;
   logic [63:0]        mag;
   logic [63:0]        rnd;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   always_comb begin
      mag = prod_ff[63] ? (64'd0 - 64'(prod_ff)) : 64'(prod_ff);
      rnd = (mag + 64'h8000) >> 16;
      mul_q = lupp_pkg::sat_mag(prod_ff[63], rnd);
   end

endmodule

@@ hdl/lupp_qdiv.sv @@
`timescale 1ns / 1ps

module lupp_qdiv (
   input  logic               clock,
   input  logic               reset,
   input  logic               div_start,
   input  lupp_pkg::q16_type  div_num,
   input  lupp_pkg::q16_type  div_den,
   output logic               div_done,
   output lupp_pkg::q16_type  div_quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] dm_ff, dm_in;
   logic        neg_ff, neg_in;
   logic [31:0] nm;
   logic [31:0] dm;
   logic [32:0] remsh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      nm      = div_num[31] ? (32'd0 - 32'(div_num)) : 32'(div_num);
      dm      = div_den[31] ? (32'd0 - 32'(div_den)) : 32'(div_den);
      remsh   = {rem_ff[31:0], quo_ff[47]};
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd48;
         rem_in  = 33'd0;
         quo_in  = {nm, 16'd0} + 48'(dm >> 1);
         dm_in   = dm;
         neg_in  = div_num[31] ^ div_den[31];
      end else if (busy_ff) begin
         if (remsh >= {1'b0, dm_ff}) begin
            rem_in = remsh - {1'b0, dm_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = remsh;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
   end

   assign div_done = done_ff;
   assign div_quot = (dm_ff == 32'd0) ? 32'sd0 : lupp_pkg::sat_mag(neg_ff, {16'd0, quo_ff});

endmodule

@@ hdl/lu_partial_pivot_solver.sv @@
`timescale 1ns / 1ps

// LU solver with partial pivoting, signed Q16.16. A problem loads as n*n matrix
// entries row-major, then n right-hand-side entries, one per transfer at one
// per cycle. The last entry starts Doolittle factorization, forward and back
// substitution; x[0..n-1] then leave on the rsp channel, or one failure result
// (status 1) if a pivot falls below the tolerance or tlast comes early. The
// solve runs on one shared multiplier, one radix-2 divider and a working
// memory with one read and one write port. A multiply-accumulate term reads
// both operands, multiplies and accumulates; a row swap exchanges the two
// rows column by column. No input is taken during a solve or while a result
// waits. No clearing pass is needed after reset.
module lu_partial_pivot_solver #(
   parameter int MAX_ORDER = 16
) (
   input  logic        clock,
   input  logic        reset,
   // element_value[31:0]
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // solution_value[31:0], solution_index[35:32], zero[39:36]
   output logic [39:0] rsp_tdata,
   // solve_status[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   localparam int NCAP = (MAX_ORDER < lupp_pkg::RESULT_CAP) ? MAX_ORDER : lupp_pkg::RESULT_CAP;
   localparam int ACC_W = 38;

   localparam logic [3:0] PH_LOAD = 4'd0;
   localparam logic [3:0] PH_PIV  = 4'd1;
   localparam logic [3:0] PH_CHK  = 4'd2;
   localparam logic [3:0] PH_SWAP = 4'd3;
   localparam logic [3:0] PH_UROW = 4'd4;
   localparam logic [3:0] PH_LCOL = 4'd5;
   localparam logic [3:0] PH_FWD  = 4'd6;
   localparam logic [3:0] PH_BACK = 4'd7;
   localparam logic [3:0] PH_OUT  = 4'd8;

   localparam logic [3:0] D_INIT = 4'd0;
   localparam logic [3:0] D_RA   = 4'd1;
   localparam logic [3:0] D_RB   = 4'd2;
   localparam logic [3:0] D_MUL  = 4'd3;
   localparam logic [3:0] D_ACC  = 4'd4;
   localparam logic [3:0] D_X    = 4'd5;
   localparam logic [3:0] D_XR   = 4'd6;
   localparam logic [3:0] D_DEN  = 4'd7;
   localparam logic [3:0] D_DENR = 4'd8;
   localparam logic [3:0] D_DIV  = 4'd9;
   localparam logic [3:0] D_DONE = 4'd10;

   logic [4:0]  order_ff;
   logic [30:0] tol_ff;

   logic [3:0]  ph_ff, ph_in;
   logic [3:0]  ds_ff, ds_in;
   logic [3:0]  k_ff, k_in;
   logic [3:0]  i_ff, i_in;
   logic [4:0]  m_ff, m_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [31:0] a_ff, a_in;
   logic signed [31:0] r_ff, r_in;
   logic [31:0] best_ff, best_in;
   logic [3:0]  piv_ff, piv_in;
   logic [4:0]  sc_ff, sc_in;
   logic [1:0]  ss_ff, ss_in;
   logic        os_ff, os_in;
   logic [31:0] sva_ff, sva_in;
   logic [3:0]  ld_row_ff, ld_row_in;
   logic [3:0]  ld_col_ff, ld_col_in;
   logic        ld_rhs_ff, ld_rhs_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic [3:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_stat_ff, rsp_stat_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] mem [0:(1 << lupp_pkg::ADDR_W)-1];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [lupp_pkg::ADDR_W-1:0] mem_waddr;
   logic [lupp_pkg::ADDR_W-1:0] mem_raddr;
   logic [31:0] mem_wdata;

   logic        mul_en;
   lupp_pkg::q16_type mul_q;
   logic        div_start;
   logic        div_done;
   lupp_pkg::q16_type div_quot;

   logic [4:0]  n;
   logic [3:0]  nm1;
   logic [3:0]  d_ra;
   logic [4:0]  d_cb;
   logic [4:0]  d_cx;
   logic [4:0]  d_cd;
   logic        d_wr;
   logic        d_div;
   logic [3:0]  d_dd;
   logic [4:0]  d_mlo;
   logic [4:0]  d_mhi;
   logic        dot_ph;
   logic        req_xfer;
   logic [31:0] r_mag;
   logic signed [38:0] diff;

   function automatic logic signed [31:0] sat_diff(input logic signed [38:0] d);
      logic signed [31:0] res;
      if (d > 39'sh00_7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else if (d < -39'sh00_8000_0000) res = 32'sh8000_0000;
      else res = 32'(d);
      return res;
   endfunction

   lupp_qmul u_qmul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (lupp_pkg::q16_type'(a_ff)),
      .mul_b  (lupp_pkg::q16_type'(rdata_ff)),
      .mul_q  (mul_q)
   );

   lupp_qdiv u_qdiv (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (r_ff),
      .div_den   (lupp_pkg::q16_type'(rdata_ff)),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

   always_comb begin
      if (order_ff == 5'd0) n = 5'd1;
      else if (order_ff > 5'(NCAP)) n = 5'(NCAP);
      else n = order_ff;
      nm1 = 4'(n - 5'd1);
   end

   always_comb begin
      d_ra  = i_ff;
      d_cb  = {1'b0, k_ff};
      d_cx  = {1'b0, k_ff};
      d_cd  = {1'b0, k_ff};
      d_wr  = 1'b0;
      d_div = 1'b0;
      d_dd  = k_ff;
      d_mlo = 5'd0;
      d_mhi = {1'b0, k_ff};
      case (ph_ff)
         PH_UROW: begin
            d_ra = k_ff;
            d_cb = {1'b0, i_ff};
            d_cx = {1'b0, i_ff};
            d_cd = {1'b0, i_ff};
            d_wr = 1'b1;
         end
         PH_LCOL: begin
            d_wr  = 1'b1;
            d_div = 1'b1;
         end
         PH_FWD: begin
            d_cb  = lupp_pkg::BCOL;
            d_cx  = lupp_pkg::BCOL;
            d_cd  = lupp_pkg::BCOL;
            d_wr  = 1'b1;
            d_mhi = {1'b0, i_ff};
         end
         PH_BACK: begin
            d_cb  = lupp_pkg::XCOL;
            d_cx  = lupp_pkg::BCOL;
            d_cd  = lupp_pkg::XCOL;
            d_wr  = 1'b1;
            d_div = 1'b1;
            d_dd  = i_ff;
            d_mlo = {1'b0, i_ff} + 5'd1;
            d_mhi = n;
         end
         default: begin
         end
      endcase
   end

   assign dot_ph   = (ph_ff == PH_PIV) || (ph_ff == PH_UROW) || (ph_ff == PH_LCOL)
                     || (ph_ff == PH_FWD) || (ph_ff == PH_BACK);
   assign req_tready = (ph_ff == PH_LOAD) && !rsp_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign r_mag      = r_ff[31] ? (32'd0 - 32'(r_ff)) : 32'(r_ff);
   assign diff       = 39'(signed'(rdata_ff)) - 39'(acc_ff);

   always_comb begin
      case (ph_ff)
         PH_SWAP: mem_raddr = (ss_ff == 2'd0) ? {k_ff, sc_ff} : {piv_ff, sc_ff};
         PH_OUT:  mem_raddr = {i_ff, lupp_pkg::XCOL};
         default: begin
            case (ds_ff)
               D_RA:    mem_raddr = {d_ra, 1'b0, m_ff[3:0]};
               D_RB:    mem_raddr = {m_ff[3:0], d_cb};
               D_DEN:   mem_raddr = {d_dd, 1'b0, d_dd};
               default: mem_raddr = {d_ra, d_cx};
            endcase
         end
      endcase
   end

   always_comb begin
      ph_in        = ph_ff;
      ds_in        = ds_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      r_in         = r_ff;
      best_in      = best_ff;
      piv_in       = piv_ff;
      sc_in        = sc_ff;
      ss_in        = ss_ff;
      os_in        = os_ff;
      sva_in       = sva_ff;
      ld_row_in    = ld_row_ff;
      ld_col_in    = ld_col_ff;
      ld_rhs_in    = ld_rhs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = {d_ra, d_cd};
      mem_wdata    = 32'(r_ff);
      mul_en       = 1'b0;
      div_start    = 1'b0;

      case (ph_ff)
         PH_LOAD: begin
            if (req_xfer) begin
               mem_we    = 1'b1;
               mem_wdata = req_tdata;
               if (!ld_rhs_ff) begin
                  mem_waddr = {ld_row_ff, 1'b0, ld_col_ff};
                  if (ld_col_ff == nm1) begin
                     ld_col_in = 4'd0;
                     if (ld_row_ff == nm1) begin
                        ld_row_in = 4'd0;
                        ld_rhs_in = 1'b1;
                     end else begin
                        ld_row_in = ld_row_ff + 4'd1;
                     end
                  end else begin
                     ld_col_in = ld_col_ff + 4'd1;
                  end
               end else begin
                  mem_waddr = {ld_row_ff, lupp_pkg::BCOL};
                  ld_row_in = ld_row_ff + 4'd1;
               end
               if (ld_rhs_ff && (ld_row_ff == nm1)) begin
                  ld_row_in = 4'd0;
                  ld_col_in = 4'd0;
                  ld_rhs_in = 1'b0;
                  ph_in     = PH_PIV;
                  ds_in     = D_INIT;
                  k_in      = 4'd0;
                  i_in      = 4'd0;
                  best_in   = 32'd0;
                  piv_in    = 4'd0;
               end else if (req_tlast) begin
                  ld_row_in    = 4'd0;
                  ld_col_in    = 4'd0;
                  ld_rhs_in    = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_val_in   = 32'd0;
                  rsp_idx_in   = 4'd0;
                  rsp_stat_in  = lupp_pkg::STATUS_FAILED;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         PH_CHK: begin
            if ((best_ff == 32'd0) || (best_ff < {1'b0, tol_ff})) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = 32'd0;
               rsp_idx_in   = 4'd0;
               rsp_stat_in  = lupp_pkg::STATUS_FAILED;
               rsp_last_in  = 1'b1;
               ph_in        = PH_LOAD;
            end else if (piv_ff == k_ff) begin
               ph_in = PH_UROW;
               i_in  = k_ff;
               ds_in = D_INIT;
            end else begin
               ph_in = PH_SWAP;
               sc_in = 5'd0;
               ss_in = 2'd0;
            end
         end
         PH_SWAP: begin
            ss_in = ss_ff + 2'd1;
            case (ss_ff)
               2'd1: sva_in = rdata_ff;
               2'd2: begin
                  mem_we    = 1'b1;
                  mem_waddr = {k_ff, sc_ff};
                  mem_wdata = rdata_ff;
               end
               2'd3: begin
                  mem_we    = 1'b1;
                  mem_waddr = {piv_ff, sc_ff};
                  mem_wdata = sva_ff;
                  if (sc_ff == lupp_pkg::BCOL) begin
                     ph_in = PH_UROW;
                     i_in  = k_ff;
                     ds_in = D_INIT;
                  end else if (sc_ff[3:0] == nm1) begin
                     sc_in = lupp_pkg::BCOL;
                  end else begin
                     sc_in = sc_ff + 5'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         PH_OUT: begin
            if (!os_ff) begin
               os_in = 1'b1;
            end else if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = rdata_ff;
               rsp_idx_in   = i_ff;
               rsp_stat_in  = lupp_pkg::STATUS_SOLVED;
               rsp_last_in  = (i_ff == nm1);
               os_in        = 1'b0;
               if (i_ff == nm1) ph_in = PH_LOAD;
               else i_in = i_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase

      if (dot_ph) begin
         case (ds_ff)
            D_INIT: begin
               acc_in = '0;
               m_in   = d_mlo;
               ds_in  = (d_mlo >= d_mhi) ? D_X : D_RA;
            end
            D_RA: ds_in = D_RB;
            D_RB: begin
               a_in  = rdata_ff;
               ds_in = D_MUL;
            end
            D_MUL: begin
               mul_en = 1'b1;
               ds_in  = D_ACC;
            end
            D_ACC: begin
               acc_in = acc_ff + ACC_W'(mul_q);
               m_in   = m_ff + 5'd1;
               ds_in  = ((m_ff + 5'd1) == d_mhi) ? D_X : D_RA;
            end
            D_X: ds_in = D_XR;
            D_XR: begin
               r_in  = sat_diff(diff);
               ds_in = d_div ? D_DEN : D_DONE;
            end
            D_DEN: ds_in = D_DENR;
            D_DENR: begin
               div_start = 1'b1;
               ds_in     = D_DIV;
            end
            D_DIV: begin
               if (div_done) begin
                  r_in  = div_quot;
                  ds_in = D_DONE;
               end
            end
            D_DONE: begin
               mem_we = d_wr;
               ds_in  = D_INIT;
               case (ph_ff)
                  PH_PIV: begin
                     if (r_mag > best_ff) begin
                        best_in = r_mag;
                        piv_in  = i_ff;
                     end
                     if (i_ff == nm1) ph_in = PH_CHK;
                     else i_in = i_ff + 4'd1;
                  end
                  PH_UROW, PH_LCOL: begin
                     if (i_ff != nm1) begin
                        i_in = i_ff + 4'd1;
                     end else if ((ph_ff == PH_UROW) && (k_ff != nm1)) begin
                        ph_in = PH_LCOL;
                        i_in  = k_ff + 4'd1;
                     end else if (k_ff == nm1) begin
                        ph_in = PH_FWD;
                        i_in  = 4'd0;
                     end else begin
                        ph_in   = PH_PIV;
                        k_in    = k_ff + 4'd1;
                        i_in    = k_ff + 4'd1;
                        best_in = 32'd0;
                        piv_in  = k_ff + 4'd1;
                     end
                  end
                  PH_FWD: begin
                     if (i_ff == nm1) ph_in = PH_BACK;
                     else i_in = i_ff + 4'd1;
                  end
                  default: begin
                     if (i_ff == 4'd0) begin
                        ph_in = PH_OUT;
                        os_in = 1'b0;
                     end else begin
                        i_in = i_ff - 4'd1;
                     end
                  end
               endcase
            end
            default: ds_in = D_INIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= 5'd16;
         tol_ff       <= 31'd66;
         ph_ff        <= PH_LOAD;
         ds_ff        <= D_INIT;
         ss_ff        <= 2'd0;
         os_ff        <= 1'b0;
         ld_row_ff    <= 4'd0;
         ld_col_ff    <= 4'd0;
         ld_rhs_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == lupp_pkg::REG_ORDER)) order_ff <= csr_wdata[4:0];
         if (csr_we && (csr_index == lupp_pkg::REG_TOLERANCE)) tol_ff <= csr_wdata;
         ph_ff        <= ph_in;
         ds_ff        <= ds_in;
         ss_ff        <= ss_in;
         os_ff        <= os_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         ld_rhs_ff    <= ld_rhs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      i_ff        <= i_in;
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      r_ff        <= r_in;
      best_ff     <= best_in;
      piv_ff      <= piv_in;
      sc_ff       <= sc_in;
      sva_ff      <= sva_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_idx_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
